// ===== hw/rtl/lrt_pkg.sv =====
// Shared types, constants and saturation helpers of the LMS regression trainer.
package lrt_pkg;

   // Input feature and target width (signed Q8.8 at the default width)
   localparam int FEATURE_BITS = 16;

   // Weight, prediction and error width (signed Q16.16)
   localparam int WEIGHT_W = 32;
   localparam int NUM_W    = 4;
   localparam int IDX_W    = $clog2(NUM_W);

   // Shared multiplier: 33 x 33 signed covers weights, errors, magnitudes and features
   localparam int MUL_W  = WEIGHT_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   // Dot product accumulator: four terms of PROD_W - 8 bits
   localparam int ACC_W  = PROD_W - 8 + 2;

   // Error sum and gradient widths; the magnitude reaches 2^31, so its square needs 63 bits
   localparam int SSE_W  = 48;
   localparam int SQ_W   = 2 * WEIGHT_W - 1 - 17;
   localparam int GRAD_W = 48;
   localparam int LR_W   = 16;
   localparam int STEP_W = GRAD_W + LR_W + 1;

   // Bias feature: 1.0 in Q8.8
   localparam logic signed [MUL_W-1:0] ONE_Q8_8 = MUL_W'(256);

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MODE          = CSR_IDX_W'(1);
   localparam logic [LR_W-1:0]      LR_RESET          = LR_W'(328);

   localparam logic [SSE_W-1:0] SSE_MAX = {SSE_W{1'b1}};

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load_in;   // capture a new sample, clear accumulator
      logic             dot_mul;   // product of weight and feature at idx
      logic             dot_acc;   // accumulate the previous product
      logic             err_en;    // saturate prediction, form error
      logic             sq_mul;    // square of the error magnitude
      logic             sse_en;    // add half squared error to the sum
      logic             grad_mul;  // product of error and feature at idx
      logic             step_mul;  // gradient times learning rate
      logic             w_upd;     // write updated weight at idx
      logic             out_load;  // move the result into the output register
      logic [IDX_W-1:0] idx;
   } lrt_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic mode_eval;  // evaluate only, no weight update
      logic out_busy;   // output register holds a result not taken this cycle
   } lrt_sts_type;

   // Saturate a signed value to 32 bits
   function automatic logic signed [WEIGHT_W-1:0] sat_to_32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
         return v[WEIGHT_W-1:0];
      end
   endfunction

   // Saturate a signed value to 48 bits
   function automatic logic signed [GRAD_W-1:0] sat_to_48(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_7FFF_FFFF_FFFF;
      lo = -64'sh0000_8000_0000_0000;
      if (v > hi) begin
         return {1'b0, {(GRAD_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(GRAD_W-1){1'b0}}};
      end else begin
         return v[GRAD_W-1:0];
      end
   endfunction

endpackage

// ===== hw/rtl/lrt_ctrl.sv =====
// Controller state machine of the LMS regression trainer: sequences one sample.
module lrt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lrt_pkg::lrt_sts_type sts,
   output lrt_pkg::lrt_cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_DOT  = 9'b000000010,
      ST_ERR  = 9'b000000100,
      ST_SQR  = 9'b000001000,
      ST_SSE  = 9'b000010000,
      ST_GRAD = 9'b000100000,
      ST_STEP = 9'b001000000,
      ST_UPD  = 9'b010000000,
      ST_DONE = 9'b100000000
   } lrt_state_type;

   localparam logic [2:0] DOT_LAST = 3'(lrt_pkg::NUM_W);
   localparam logic [lrt_pkg::IDX_W-1:0] IDX_LAST = lrt_pkg::IDX_W'(lrt_pkg::NUM_W - 1);

   lrt_state_type state_ff, state_in;
   logic [2:0]    cnt_ff, cnt_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.idx  = cnt_ff[lrt_pkg::IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               cnt_in      = '0;
               state_in    = ST_DOT;
            end
         end
         ST_DOT: begin
            // multiply at counts 0..3, accumulate one count behind
            cmd.dot_mul = (cnt_ff != DOT_LAST);
            cmd.dot_acc = (cnt_ff != 3'd0);
            if (cnt_ff == DOT_LAST) begin
               cnt_in   = '0;
               state_in = ST_ERR;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            state_in   = ST_SQR;
         end
         ST_SQR: begin
            cmd.sq_mul = 1'b1;
            state_in   = ST_SSE;
         end
         ST_SSE: begin
            cmd.sse_en = 1'b1;
            cnt_in     = '0;
            state_in   = sts.mode_eval ? ST_DONE : ST_GRAD;
         end
         ST_GRAD: begin
            cmd.grad_mul = 1'b1;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            cmd.step_mul = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.w_upd = 1'b1;
            if (cnt_ff[lrt_pkg::IDX_W-1:0] == IDX_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 3'd1;
               state_in = ST_GRAD;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lrt_datapath.sv =====
// Datapath of the LMS regression trainer: weights, shared multiplier, error sum, outputs.
module lrt_datapath (
   input  logic                                        clock,
   input  logic                                        reset,
   input  lrt_pkg::lrt_cmd_type                        cmd,
   output lrt_pkg::lrt_sts_type                        sts,
   input  logic                                        csr_valid,
   input  logic [lrt_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [lrt_pkg::CSR_DATA_W-1:0]              csr_data,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0]     req_feature_one,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0]     req_feature_two,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0]     req_feature_three,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0]     req_target,
   input  logic                                        req_epoch_end,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [lrt_pkg::WEIGHT_W-1:0]         rsp_prediction,
   output logic signed [lrt_pkg::WEIGHT_W-1:0]         rsp_error,
   output logic [lrt_pkg::SSE_W-1:0]                   rsp_epoch_sse,
   output logic                                        rsp_last
);

   localparam int MW = lrt_pkg::MUL_W;
   localparam int FB = lrt_pkg::FEATURE_BITS;

   // Configuration
   logic [lrt_pkg::LR_W-1:0] lr_ff;
   logic                     mode_ff;

   // Sample and model state
   logic signed [MW-1:0]                x_ff [lrt_pkg::NUM_W];
   logic signed [MW-1:0]                tgt_ff;
   logic                                end_ff;
   logic signed [lrt_pkg::WEIGHT_W-1:0] w_ff [lrt_pkg::NUM_W];
   logic [lrt_pkg::SSE_W-1:0]           sse_ff;

   // Arithmetic registers
   logic signed [lrt_pkg::PROD_W-1:0]   prod_ff;
   logic signed [lrt_pkg::ACC_W-1:0]    acc_ff;
   logic signed [lrt_pkg::WEIGHT_W-1:0] pred_ff;
   logic signed [lrt_pkg::WEIGHT_W-1:0] err_ff;
   logic signed [lrt_pkg::STEP_W-1:0]   step_ff;
   logic                                out_valid_ff;

   logic signed [MW-1:0]                mul_a, mul_b, mag;
   logic signed [lrt_pkg::WEIGHT_W-1:0] pred_sat;
   logic signed [63:0]                  diff;
   logic signed [lrt_pkg::GRAD_W-1:0]   grad;
   logic signed [lrt_pkg::LR_W:0]       lr_s;
   logic [lrt_pkg::SQ_W-1:0]            sq;
   logic [lrt_pkg::SSE_W:0]             sse_sum;
   logic signed [lrt_pkg::WEIGHT_W-1:0] w_new;

   // Configuration registers, to be written while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= lrt_pkg::LR_RESET;
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            lrt_pkg::CSR_LEARNING_RATE: lr_ff   <= csr_data[lrt_pkg::LR_W-1:0];
            lrt_pkg::CSR_MODE:          mode_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Sample capture; the bias weight sees a constant feature of 1.0
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff[0] <= lrt_pkg::ONE_Q8_8;
         x_ff[1] <= {{(MW-FB){req_feature_one[FB-1]}}, req_feature_one};
         x_ff[2] <= {{(MW-FB){req_feature_two[FB-1]}}, req_feature_two};
         x_ff[3] <= {{(MW-FB){req_feature_three[FB-1]}}, req_feature_three};
         tgt_ff  <= {{(MW-FB){req_target[FB-1]}}, req_target};
         end_ff  <= req_epoch_end;
      end
   end

   // Error magnitude for the square
   assign mag = (err_ff < 0) ? -MW'(err_ff) : MW'(err_ff);

   // Operand select of the shared multiplier
   always_comb begin
      mul_a = MW'(w_ff[cmd.idx]);
      mul_b = x_ff[cmd.idx];
      if (cmd.sq_mul) begin
         mul_a = mag;
         mul_b = mag;
      end else if (cmd.grad_mul) begin
         mul_a = MW'(err_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dot_mul || cmd.sq_mul || cmd.grad_mul) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Dot product accumulation, each term floored by 8 bits
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         acc_ff <= '0;
      end else if (cmd.dot_acc) begin
         acc_ff <= acc_ff + lrt_pkg::ACC_W'(prod_ff >>> 8);
      end
   end

   // Prediction and error, both saturated
   assign pred_sat = lrt_pkg::sat_to_32(64'(acc_ff));
   assign diff     = 64'(pred_sat) - (64'(tgt_ff) <<< 8);

   always_ff @(posedge clock) begin
      if (cmd.err_en) begin
         pred_ff <= pred_sat;
         err_ff  <= lrt_pkg::sat_to_32(diff);
      end
   end

   // Half squared error into the saturating epoch sum
   assign sq      = prod_ff[lrt_pkg::SQ_W+16:17];
   assign sse_sum = {1'b0, sse_ff} + (lrt_pkg::SSE_W+1)'(sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         sse_ff <= '0;
      end else if (cmd.sse_en) begin
         sse_ff <= sse_sum[lrt_pkg::SSE_W] ? lrt_pkg::SSE_MAX : sse_sum[lrt_pkg::SSE_W-1:0];
      end else if (cmd.out_load && end_ff) begin
         sse_ff <= '0;
      end
   end

   // Gradient saturated to 48 bits, then scaled by the learning rate
   assign grad = lrt_pkg::sat_to_48(64'(prod_ff >>> 8));
   assign lr_s = $signed({1'b0, lr_ff});

   always_ff @(posedge clock) begin
      if (cmd.step_mul) begin
         step_ff <= grad * lr_s;
      end
   end

   // Weight update with saturation
   assign w_new = lrt_pkg::sat_to_32(64'(w_ff[cmd.idx]) - 64'(step_ff >>> 16));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < lrt_pkg::NUM_W; j++) begin
            w_ff[j] <= '0;
         end
      end else if (cmd.w_upd) begin
         w_ff[cmd.idx] <= w_new;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_prediction <= pred_ff;
         rsp_error      <= err_ff;
         rsp_epoch_sse  <= sse_ff;
         rsp_last       <= end_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign sts.mode_eval = mode_ff;
   assign sts.out_busy  = out_valid_ff && rsp_stall;

endmodule

// ===== hw/rtl/lms_regression_trainer_top.sv =====
// Top level of the LMS regression trainer: controller and datapath.
// Train mode runs the dot product, error, square, error sum and the per-weight updates; evaluate
// mode stops after the error sum. A new sample is accepted only once the last one is done; the
// shared multiplier is used for the four dot terms, the square and each gradient product.
// A result waiting in the output register holds the controller in its done state, so the next sample waits.
// Reset (synchronous): weights and error sum zero, learning_rate 328, mode train.
module lms_regression_trainer_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0] req_feature_one,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0] req_feature_two,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0] req_feature_three,
   input  logic signed [lrt_pkg::FEATURE_BITS-1:0] req_target,
   input  logic                                    req_epoch_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [lrt_pkg::WEIGHT_W-1:0]     rsp_prediction,
   output logic signed [lrt_pkg::WEIGHT_W-1:0]     rsp_error,
   output logic [lrt_pkg::SSE_W-1:0]               rsp_epoch_sse,
   output logic                                    rsp_last,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lrt_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lrt_pkg::CSR_DATA_W-1:0]          csr_data
);

   lrt_pkg::lrt_cmd_type cmd;
   lrt_pkg::lrt_sts_type sts;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   lrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_feature_one   (req_feature_one),
      .req_feature_two   (req_feature_two),
      .req_feature_three (req_feature_three),
      .req_target        (req_target),
      .req_epoch_end     (req_epoch_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_prediction    (rsp_prediction),
      .rsp_error         (rsp_error),
      .rsp_epoch_sse     (rsp_epoch_sse),
      .rsp_last          (rsp_last)
   );

endmodule
